/* hw/rtl/lbbt_pkg.sv */
// Shared types, codes and defaults for the label bounding box table.
package lbbt_pkg;

  localparam int DEF_LABEL_COUNT = 1024;
  localparam int DEF_MAX_SIDE    = 4096;

  localparam int LABEL_W   = 10;
  localparam int WSIZE_W   = 12;
  localparam int SHIFT_W   = WSIZE_W - 1;
  localparam int FIELD_W   = 12;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] DEF_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] DEF_HEIGHT = 13'd480;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EVEN    = 2'd1,
    STATUS_TOO_BIG = 2'd2,
    STATUS_ABSENT  = 2'd3
  } status_t;

  typedef struct packed {
    logic               operation;
    logic               start_of_frame;
    logic [LABEL_W-1:0] label;
    logic [WSIZE_W-1:0] window_size;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  box_left;
    logic [FIELD_W-1:0]  box_right;
    logic [FIELD_W-1:0]  box_top;
    logic [FIELD_W-1:0]  box_bottom;
    logic [FIELD_W-1:0]  window_left;
    logic [FIELD_W-1:0]  window_top;
    logic [FIELD_W-1:0]  window_right;
    logic [FIELD_W-1:0]  window_bottom;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic rd_own;
    logic clr_we;
    logic load_item;
    logic pix_write;
    logic calc;
    logic low;
    logic load_out;
  } lbbt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic in_op;
    logic in_sof;
    logic item_op;
  } lbbt_sts_t;

endpackage

/* hw/rtl/label_bounding_box_table.sv */
// Per-label bounding box table with a centred window query.
// Pixel item: one memory read then a read-modify-write of the box entry.
// Query item: centre, low and high steps; in_stall holds until the result loads.
// Start of frame: a pass clears the box memory, then a re-read of the item's entry.
// Reset: the same clearing pass runs with in_stall high.
module label_bounding_box_table import lbbt_pkg::*; #(
  parameter int LABEL_COUNT = DEF_LABEL_COUNT,
  parameter int MAX_SIDE    = DEF_MAX_SIDE
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  lbbt_cmd_t cmd;
  lbbt_sts_t sts;

  lbbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbbt_dpath #(
    .LABEL_COUNT (LABEL_COUNT),
    .MAX_SIDE    (MAX_SIDE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* hw/rtl/lbbt_ctrl.sv */
// Sequencer for the label bounding box table: clearing, update and query steps.
module lbbt_ctrl import lbbt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lbbt_sts_t sts,
  output lbbt_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_INIT   = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_FLUSH  = 8'b00000100,
    S_READ   = 8'b00001000,
    S_UPDATE = 8'b00010000,
    S_CENTER = 8'b00100000,
    S_LOW    = 8'b01000000,
    S_HIGH   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (sts.in_sof) begin
            state_nxt = S_FLUSH;
          end else if (sts.in_op == OP_QUERY) begin
            state_nxt = S_CENTER;
          end else begin
            state_nxt = S_UPDATE;
          end
        end
      end
      S_FLUSH: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_own = 1'b1;
        state_nxt  = (sts.item_op == OP_QUERY) ? S_CENTER : S_UPDATE;
      end
      S_UPDATE: begin
        cmd.pix_write = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_CENTER: begin
        cmd.calc  = 1'b1;
        state_nxt = S_LOW;
      end
      S_LOW: begin
        cmd.low   = 1'b1;
        state_nxt = S_HIGH;
      end
      S_HIGH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

/* hw/rtl/lbbt_dpath.sv */
// Datapath: box memory, raster position, window arithmetic and result register.
module lbbt_dpath import lbbt_pkg::*; #(
  parameter int LABEL_COUNT = DEF_LABEL_COUNT,
  parameter int MAX_SIDE    = DEF_MAX_SIDE
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  lbbt_cmd_t            cmd,
  output lbbt_sts_t            sts
);

  localparam int LBL_W  = $clog2(LABEL_COUNT);
  localparam int POS_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int SHW    = (POS_W > SHIFT_W) ? POS_W : SHIFT_W;
  localparam int CMP_W  = (SIDE_W > WSIZE_W) ? SIDE_W : WSIZE_W;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] min_col;
    logic [POS_W-1:0] max_col;
    logic [POS_W-1:0] min_row;
    logic [POS_W-1:0] max_row;
  } entry_t;

  function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_W-1:0] v);
    logic [SIDE_W-1:0] s;
    if (v == '0) begin
      s = SIDE_W'(1);
    end else if (32'(v) > MAX_SIDE) begin
      s = SIDE_W'(MAX_SIDE);
    end else begin
      s = SIDE_W'(v);
    end
    return s;
  endfunction

  entry_t mem [LABEL_COUNT];
  entry_t rd_q_r;

  logic [SIDE_W-1:0] eff_w_r, eff_h_r;
  in_item_t          item_r;
  logic [POS_W-1:0]  col_r;
  logic [SIDE_W-1:0] row_r;
  logic [LBL_W-1:0]  clr_cnt_r;

  logic [POS_W-1:0]    bl_r, br_r, bt_r, bb_r;
  logic [POS_W-1:0]    cx_r, cy_r;
  logic [SHIFT_W-1:0]  shift_r;
  status_t             status_r;
  logic [POS_W-1:0]    left_r, top_r;

  out_item_t out_r;
  logic      out_valid_r;

  logic [LBL_W-1:0] item_addr, rd_addr, wr_addr;
  logic             lbl_ok, row_ok, clr_last, wr_en, present, wrap;
  entry_t           merged, wr_data;
  logic [POS_W-1:0] cur_row;
  logic [CMP_W-1:0] ws_e;
  status_t          status_nxt;

  logic [SHW-1:0]   cx_e, cy_e, sh_e;
  logic [POS_W:0]   right_raw, bottom_raw;
  logic [POS_W-1:0] right_lim, bottom_lim, right_v, bottom_v;

  assign item_addr = LBL_W'(item_r.label);
  assign lbl_ok    = 32'(item_r.label) < LABEL_COUNT;
  assign row_ok    = row_r < eff_h_r;
  assign clr_last  = clr_cnt_r == LBL_W'(LABEL_COUNT - 1);
  assign cur_row   = POS_W'(row_r);
  assign wrap      = (SIDE_W'(col_r) + SIDE_W'(1)) >= eff_w_r;

  assign sts.clr_last = clr_last;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.in_op    = in_data.operation;
  assign sts.in_sof   = in_data.start_of_frame;
  assign sts.item_op  = item_r.operation;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= eff_side(DEF_WIDTH);
      eff_h_r <= eff_side(DEF_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  eff_w_r <= eff_side(cfg_wdata);
        REG_IMAGE_HEIGHT: eff_h_r <= eff_side(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  // raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.load_item && in_data.start_of_frame) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.pix_write && row_ok) begin
      if (wrap) begin
        col_r <= '0;
        row_r <= row_r + SIDE_W'(1);
      end else begin
        col_r <= col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_last ? '0 : clr_cnt_r + LBL_W'(1);
    end
  end

  // box memory
  always_comb begin
    if (!rd_q_r.valid) begin
      merged = '{valid: 1'b1, min_col: col_r, max_col: col_r,
                 min_row: cur_row, max_row: cur_row};
    end else begin
      merged         = rd_q_r;
      merged.min_col = (col_r < rd_q_r.min_col) ? col_r : rd_q_r.min_col;
      merged.max_col = (col_r > rd_q_r.max_col) ? col_r : rd_q_r.max_col;
      merged.min_row = (cur_row < rd_q_r.min_row) ? cur_row : rd_q_r.min_row;
      merged.max_row = (cur_row > rd_q_r.max_row) ? cur_row : rd_q_r.max_row;
    end
  end

  assign rd_addr = cmd.rd_own ? item_addr : LBL_W'(in_data.label);
  assign wr_en   = cmd.clr_we || (cmd.pix_write && row_ok && lbl_ok);
  assign wr_addr = cmd.clr_we ? clr_cnt_r : item_addr;
  assign wr_data = cmd.clr_we ? entry_t'('0) : merged;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // query: box, centre and status
  assign present = lbl_ok && rd_q_r.valid;
  assign ws_e    = CMP_W'(item_r.window_size);

  always_comb begin
    if (!item_r.window_size[0]) begin
      status_nxt = STATUS_EVEN;
    end else if (ws_e > CMP_W'(eff_h_r) || ws_e > CMP_W'(eff_w_r)) begin
      status_nxt = STATUS_TOO_BIG;
    end else if (!present) begin
      status_nxt = STATUS_ABSENT;
    end else begin
      status_nxt = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      bl_r     <= present ? rd_q_r.min_col : '0;
      br_r     <= present ? rd_q_r.max_col : '0;
      bt_r     <= present ? rd_q_r.min_row : '0;
      bb_r     <= present ? rd_q_r.max_row : '0;
      cx_r     <= POS_W'(({1'b0, rd_q_r.min_col} + {1'b0, rd_q_r.max_col}) >> 1);
      cy_r     <= POS_W'(({1'b0, rd_q_r.min_row} + {1'b0, rd_q_r.max_row}) >> 1);
      shift_r  <= item_r.window_size[WSIZE_W-1:1];
      status_r <= status_nxt;
    end
  end

  // low window edges, clamped at zero
  assign cx_e = SHW'(cx_r);
  assign cy_e = SHW'(cy_r);
  assign sh_e = SHW'(shift_r);

  always_ff @(posedge clk) begin
    if (cmd.low) begin
      left_r <= (cx_e >= sh_e) ? POS_W'(cx_e - sh_e) : '0;
      top_r  <= (cy_e >= sh_e) ? POS_W'(cy_e - sh_e) : '0;
    end
  end

  // high window edges, mirrored and clamped to the image
  assign right_raw  = {cx_r, 1'b0} - {1'b0, left_r};
  assign bottom_raw = {cy_r, 1'b0} - {1'b0, top_r};
  assign right_lim  = POS_W'(eff_w_r - SIDE_W'(1));
  assign bottom_lim = POS_W'(eff_h_r - SIDE_W'(1));
  assign right_v    = (right_raw > {1'b0, right_lim}) ? right_lim : POS_W'(right_raw);
  assign bottom_v   = (bottom_raw > {1'b0, bottom_lim}) ? bottom_lim : POS_W'(bottom_raw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.box_left      <= FIELD_W'(bl_r);
      out_r.box_right     <= FIELD_W'(br_r);
      out_r.box_top       <= FIELD_W'(bt_r);
      out_r.box_bottom    <= FIELD_W'(bb_r);
      out_r.window_left   <= (status_r == STATUS_OK) ? FIELD_W'(left_r) : '0;
      out_r.window_top    <= (status_r == STATUS_OK) ? FIELD_W'(top_r) : '0;
      out_r.window_right  <= (status_r == STATUS_OK) ? FIELD_W'(right_v) : '0;
      out_r.window_bottom <= (status_r == STATUS_OK) ? FIELD_W'(bottom_v) : '0;
      out_r.status        <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* bench/label_bounding_box_table_tb.sv */
// Self-checking bench for the label bounding box table: raster frames, box queries, resizes.
module label_bounding_box_table_tb;
  import lbbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD      = 8;
  localparam int LABELS      = DEF_LABEL_COUNT;
  localparam int SETTLE      = DEF_LABEL_COUNT + 64;
  localparam int PHASE_ITEMS = 66;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  label_bounding_box_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(PERIOD / 2) clk = ~clk;

  // predicted block state
  logic [CFG_W-1:0]   width_reg  = DEF_WIDTH;
  logic [CFG_W-1:0]   height_reg = DEF_HEIGHT;
  logic [FIELD_W-1:0] left_col [LABELS];
  logic [FIELD_W-1:0] right_col[LABELS];
  logic [FIELD_W-1:0] top_row  [LABELS];
  logic [FIELD_W-1:0] bot_row  [LABELS];
  bit                 label_seen[LABELS];
  int unsigned        col_pos = 0;
  int unsigned        row_pos = 0;

  in_item_t    item_q[$];
  out_item_t   answer_q[$];
  out_item_t   want;
  int unsigned queued_items = 0;
  int unsigned mismatches = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          in_gaps_on = 1'b1;
  bit          out_stalls_on = 1'b1;

  function automatic int unsigned eff_side(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DEF_MAX_SIDE) return DEF_MAX_SIDE;
    return v;
  endfunction

  function automatic void window_span(input int unsigned lo, input int unsigned hi,
                                      input int unsigned shift, input int unsigned side,
                                      output int unsigned first, output int unsigned last);
    int unsigned mid;
    mid   = (lo + hi) / 2;
    first = (mid >= shift) ? mid - shift : 0;
    last  = 2 * mid - first;
    if (last > side - 1) last = side - 1;
  endfunction

  task automatic update_box_table(input in_item_t it);
    int unsigned w, h, ns, shift, wl, wr, wt, wb;
    bit          present;
    status_t     st;
    out_item_t   ans;
    w = eff_side(width_reg);
    h = eff_side(height_reg);
    if (it.start_of_frame) begin
      foreach (label_seen[i]) label_seen[i] = 1'b0;
      col_pos = 0;
      row_pos = 0;
    end
    if (it.operation == OP_PIXEL) begin
      if (row_pos < h) begin
        if (!label_seen[it.label]) begin
          label_seen[it.label] = 1'b1;
          left_col[it.label]  = FIELD_W'(col_pos);
          right_col[it.label] = FIELD_W'(col_pos);
          top_row[it.label]   = FIELD_W'(row_pos);
          bot_row[it.label]   = FIELD_W'(row_pos);
        end else begin
          if (col_pos < left_col[it.label])  left_col[it.label]  = FIELD_W'(col_pos);
          if (col_pos > right_col[it.label]) right_col[it.label] = FIELD_W'(col_pos);
          if (row_pos < top_row[it.label])   top_row[it.label]   = FIELD_W'(row_pos);
          if (row_pos > bot_row[it.label])   bot_row[it.label]   = FIELD_W'(row_pos);
        end
        if (col_pos + 1 >= w) begin
          col_pos = 0;
          row_pos++;
        end else begin
          col_pos++;
        end
      end
    end else begin
      ans     = '0;
      ns      = it.window_size;
      present = label_seen[it.label];
      if (present) begin
        ans.box_left   = left_col[it.label];
        ans.box_right  = right_col[it.label];
        ans.box_top    = top_row[it.label];
        ans.box_bottom = bot_row[it.label];
      end
      if (ns % 2 == 0) st = STATUS_EVEN;
      else if (ns > h || ns > w) st = STATUS_TOO_BIG;
      else if (!present) st = STATUS_ABSENT;
      else st = STATUS_OK;
      if (st == STATUS_OK) begin
        shift = (ns - 1) / 2;
        window_span(ans.box_left, ans.box_right, shift, w, wl, wr);
        window_span(ans.box_top, ans.box_bottom, shift, h, wt, wb);
        ans.window_left   = FIELD_W'(wl);
        ans.window_right  = FIELD_W'(wr);
        ans.window_top    = FIELD_W'(wt);
        ans.window_bottom = FIELD_W'(wb);
      end
      ans.status = st;
      answer_q.push_back(ans);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned exp_v);
    if (got != exp_v) report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_v));
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) update_box_table(in_data);
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 49) == 0) in_gaps_on = !in_gaps_on;
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (item_q.size() > 0) begin
          in_data  <= item_q.pop_front();
          in_valid <= 1'b1;
          gap_left = in_gaps_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result with no query waiting");
        end else begin
          want = answer_q.pop_front();
          check_field("box_left", out_data.box_left, want.box_left);
          check_field("box_right", out_data.box_right, want.box_right);
          check_field("box_top", out_data.box_top, want.box_top);
          check_field("box_bottom", out_data.box_bottom, want.box_bottom);
          check_field("window_left", out_data.window_left, want.window_left);
          check_field("window_top", out_data.window_top, want.window_top);
          check_field("window_right", out_data.window_right, want.window_right);
          check_field("window_bottom", out_data.window_bottom, want.window_bottom);
          check_field("status", out_data.status, want.status);
        end
      end
      if ($urandom_range(0, 63) == 0) out_stalls_on = !out_stalls_on;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic push_item(input op_t op, input bit sof, input logic [LABEL_W-1:0] lab,
                           input logic [WSIZE_W-1:0] ns);
    in_item_t it;
    it.operation      = op;
    it.start_of_frame = sof;
    it.label          = lab;
    it.window_size    = ns;
    item_q.push_back(it);
    queued_items++;
  endtask

  function automatic logic [WSIZE_W-1:0] pick_window_size();
    int unsigned lim;
    lim = eff_side(width_reg);
    if (eff_side(height_reg) < lim) lim = eff_side(height_reg);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return WSIZE_W'($urandom_range(0, (lim - 1) / 2) * 2 + 1);
      6:       return WSIZE_W'($urandom_range(0, 2047) * 2);
      7:       return WSIZE_W'($urandom_range(0, 4095));
      8:       return WSIZE_W'((lim | 1) + 2 * $urandom_range(0, 1));
      default: return WSIZE_W'($urandom_range(0, 2) * 2 + 1);
    endcase
  endfunction

  // one frame: start of frame, then pixels mostly from a small label set mixed with queries
  task automatic queue_frame(input int unsigned n);
    logic [LABEL_W-1:0] palette[4];
    logic [LABEL_W-1:0] lab;
    bit                 sof;
    foreach (palette[i])
      palette[i] = ($urandom_range(0, 7) == 0) ? {LABEL_W{i[0]}} : LABEL_W'($urandom_range(0, 1023));
    push_item(($urandom_range(0, 9) == 0) ? OP_QUERY : OP_PIXEL, 1'b1, palette[0],
              pick_window_size());
    for (int unsigned k = 0; k < n; k++) begin
      sof = ($urandom_range(0, 39) == 0);
      lab = ($urandom_range(0, 4) == 0) ? LABEL_W'($urandom_range(0, 1023))
                                        : palette[$urandom_range(0, 3)];
      if ($urandom_range(0, 3) == 0) push_item(OP_QUERY, sof, lab, pick_window_size());
      else push_item(OP_PIXEL, sof, lab, WSIZE_W'($urandom_range(0, 4095)));
    end
  endtask

  task automatic wait_drained();
    while (item_q.size() != 0 || in_valid || answer_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  logic [CFG_W-1:0] phase_w[8] = '{13'd1, 13'd0, 13'd5, 13'd8191, 13'd7, 13'd4096, 13'd13, 13'd3};
  logic [CFG_W-1:0] phase_h[8] = '{13'd1, 13'd0, 13'd4, 13'd3, 13'd8191, 13'd4096, 13'd9, 13'd17};

  initial begin
    int unsigned area, start_cnt;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, at the reset image size
    push_item(OP_QUERY, 1'b0, 10'd7, 12'd3);      // absent before any pixel
    push_item(OP_PIXEL, 1'b0, 10'd7, 12'd0);
    push_item(OP_QUERY, 1'b0, 10'd7, 12'd1);
    push_item(OP_QUERY, 1'b0, 10'd7, 12'd0);      // even
    push_item(OP_QUERY, 1'b0, 10'd300, 12'd4095); // too big wins over absent
    push_item(OP_QUERY, 1'b0, 10'd7, 12'd481);
    push_item(OP_QUERY, 1'b0, 10'd7, 12'd479);
    push_item(OP_QUERY, 1'b0, 10'd300, 12'd4094); // even wins over absent
    push_item(OP_PIXEL, 1'b1, 10'd1023, 12'd0);
    push_item(OP_PIXEL, 1'b0, 10'd0, 12'd4095);
    push_item(OP_PIXEL, 1'b0, 10'd1023, 12'd0);
    push_item(OP_QUERY, 1'b0, 10'd7, 12'd5);      // cleared by start of frame
    push_item(OP_QUERY, 1'b0, 10'd1023, 12'd3);
    push_item(OP_QUERY, 1'b0, 10'd0, 12'd4);
    push_item(OP_QUERY, 1'b1, 10'd1023, 12'd1);   // query with start of frame
    push_item(OP_PIXEL, 1'b0, 10'd512, 12'd4095);
    push_item(OP_QUERY, 1'b0, 10'd512, 12'd3);
    push_item(OP_QUERY, 1'b0, 10'd512, 12'd1);
    wait_drained();

    foreach (phase_w[p]) begin
      write_reg(REG_IMAGE_WIDTH, phase_w[p]);
      write_reg(REG_IMAGE_HEIGHT, phase_h[p]);
      @(negedge clk);
      area      = eff_side(width_reg) * eff_side(height_reg);
      start_cnt = queued_items;
      while (queued_items - start_cnt < PHASE_ITEMS) begin
        if (area <= 64) queue_frame(area + $urandom_range(0, area + 3));
        else queue_frame($urandom_range(20, 60));
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("PASS label_bounding_box_table");
    end else begin
      $display("FAIL label_bounding_box_table");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("FAIL label_bounding_box_table");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lbbt_pkg.sv
hw/rtl/lbbt_ctrl.sv
hw/rtl/lbbt_dpath.sv
hw/rtl/label_bounding_box_table.sv
bench/label_bounding_box_table_tb.sv
